// ===== sv/srbc_pkg.sv =====
package srbc_pkg;

    localparam int DATA_W     = 8;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int EXP_BITS   = 16;
    localparam int RED_BITS   = 4;
    localparam int RED_STEPS  = DATA_W / RED_BITS;
    localparam int RED_CNT_W  = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
    localparam int STEP_W     = 3;
    localparam int ADDR_W     = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_EXPONENT = 1'b0;
    localparam logic REG_MODULUS  = 1'b1;

    typedef enum logic [2:0] {
        OP_LOAD = 3'd0,
        OP_RED  = 3'd1,
        OP_BASE = 3'd2,
        OP_MUL  = 3'd3,
        OP_UPD  = 3'd4,
        OP_FIN  = 3'd5
    } dp_op_t;

    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_ALWAYS   = 3'd1,
        C_NO_ITEM  = 3'd2,
        C_RED_MORE = 3'd3,
        C_EXP_MORE = 3'd4,
        C_OUT_BUSY = 3'd5
    } cond_t;

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        dp_op_t op;
        cond_t  hold;
        cond_t  jmp;
        step_t  target;
    } uword_t;

    typedef struct packed {
        dp_op_t op;
        logic   exec;
    } seq_ctrl_t;

    typedef struct packed {
        logic red_more;
        logic exp_more;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== sv/small_modulus_rsa_byte_cipher_core.sv =====
// Byte cipher with a small RSA key. An item with tuser = 0 encrypts the plaintext
// byte in tdata[15:8] and returns the quotient m / n in tdata[7:0] and the cipher
// residue (m mod n)^e mod n in tdata[15:8]. An item with tuser = 1 decrypts the
// pair (q in tdata[7:0], c in tdata[15:8]) and returns c^e mod n + q*n in
// tdata[15:8], saturated to 255 with m_axis_tuser raised when it exceeds a byte.
// Items are worked one at a time by a seven-step microprogram around two
// modular reducers (4 quotient bits a cycle); the first reduces the input
// byte and each acc * base product, the second each base * base square. The
// result is presented in the same cycle in which the next item can be accepted,
// and each exponent bit passes through the multiply, reduce and update steps.
// The next item is accepted while a result still waits in the output
// register; the last step of that item then holds until the waiting result
// is taken. Key registers:
// exponent at address 0, modulus at address 4; write them only while the
// block is idle.
module small_modulus_rsa_byte_cipher_core import srbc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // high_in[7:0], low_in[15:8]
    input  logic                  s_axis_tuser,   // func

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,   // high_out[7:0], low_out[15:8]
    output logic                  m_axis_tuser,   // overflow

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [EXP_BITS-1:0] key_exponent_reg;
    logic [DATA_W-1:0]   key_modulus_reg;

    seq_ctrl_t   ctrl;
    dp_status_t  status;
    logic        in_ready;
    logic        wr_en;
    logic        reg_sel;
    logic [DATA_W-1:0] high_out;
    logic [DATA_W-1:0] low_out;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_exponent_reg <= EXP_BITS'(1);
            key_modulus_reg  <= DATA_W'(255);
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_EXPONENT: key_exponent_reg <= pwdata[EXP_BITS-1:0];
                REG_MODULUS:  key_modulus_reg  <= pwdata[DATA_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_EXPONENT: prdata = APB_DATA_W'(key_exponent_reg);
            REG_MODULUS:  prdata = APB_DATA_W'(key_modulus_reg);
            default:      prdata = '0;
        endcase
    end

    srbc_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .status   (status),
        .ctrl     (ctrl),
        .in_ready (in_ready)
    );

    srbc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .func         (s_axis_tuser),
        .high_in      (s_axis_tdata[7:0]),
        .low_in       (s_axis_tdata[15:8]),
        .key_exponent (key_exponent_reg),
        .key_modulus  (key_modulus_reg),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .high_out     (high_out),
        .low_out      (low_out),
        .overflow     (m_axis_tuser),
        .status       (status)
    );

    assign s_axis_tready = in_ready;
    assign m_axis_tdata  = {low_out, high_out};

endmodule

// ===== sv/srbc_modred.sv =====
module srbc_modred import srbc_pkg::*; (
    input  logic              clk,
    input  logic              load,
    input  logic              step,
    input  logic [PROD_W-1:0] dividend,
    input  logic [DATA_W-1:0] modulus,
    output logic [DATA_W-1:0] rem,
    output logic [DATA_W-1:0] quot
);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] low_reg, low_next;

    // Restoring division: the upper byte is already below the modulus,
    // so only the low byte is shifted through, RED_BITS bits per step.
    always_comb
    begin
        logic [DATA_W:0]   t;
        logic [DATA_W-1:0] r;
        logic [DATA_W-1:0] l;
        r = rem_reg;
        l = low_reg;
        for (int i = 0; i < RED_BITS; i++)
        begin
            t = {r, l[DATA_W-1]};
            l = {l[DATA_W-2:0], 1'b0};
            if (t >= {1'b0, modulus})
            begin
                t    = t - {1'b0, modulus};
                l[0] = 1'b1;
            end
            r = t[DATA_W-1:0];
        end
        rem_next = r;
        low_next = l;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= dividend[PROD_W-1:DATA_W];
            low_reg <= dividend[DATA_W-1:0];
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
        end
    end

    assign rem  = rem_reg;
    assign quot = low_reg;

endmodule

// ===== sv/srbc_sequencer.sv =====
module srbc_sequencer import srbc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  dp_status_t status,
    output seq_ctrl_t  ctrl,
    output logic       in_ready
);

    localparam step_t ST_IDLE = step_t'(0);
    localparam step_t ST_RED0 = step_t'(1);
    localparam step_t ST_BASE = step_t'(2);
    localparam step_t ST_MUL  = step_t'(3);
    localparam step_t ST_RED1 = step_t'(4);
    localparam step_t ST_UPD  = step_t'(5);
    localparam step_t ST_FIN  = step_t'(6);

    step_t  pc_reg, pc_next;
    uword_t uw;
    logic   hold_now;
    logic   jmp_now;

    function automatic uword_t rom(input step_t pc);
        uword_t w;
        unique case (pc)
            ST_IDLE: w = '{op: OP_LOAD, hold: C_NO_ITEM,  jmp: C_NEVER,    target: ST_IDLE};
            ST_RED0: w = '{op: OP_RED,  hold: C_RED_MORE, jmp: C_NEVER,    target: ST_IDLE};
            ST_BASE: w = '{op: OP_BASE, hold: C_NEVER,    jmp: C_NEVER,    target: ST_IDLE};
            ST_MUL:  w = '{op: OP_MUL,  hold: C_NEVER,    jmp: C_NEVER,    target: ST_IDLE};
            ST_RED1: w = '{op: OP_RED,  hold: C_RED_MORE, jmp: C_NEVER,    target: ST_IDLE};
            ST_UPD:  w = '{op: OP_UPD,  hold: C_NEVER,    jmp: C_EXP_MORE, target: ST_MUL};
            ST_FIN:  w = '{op: OP_FIN,  hold: C_OUT_BUSY, jmp: C_ALWAYS,   target: ST_IDLE};
            default: w = '{op: OP_BASE, hold: C_NEVER,    jmp: C_ALWAYS,   target: ST_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic test(input cond_t c, input logic in_valid_i,
                                  input dp_status_t st);
        logic v;
        unique case (c)
            C_NEVER:    v = 1'b0;
            C_ALWAYS:   v = 1'b1;
            C_NO_ITEM:  v = !in_valid_i;
            C_RED_MORE: v = st.red_more;
            C_EXP_MORE: v = st.exp_more;
            C_OUT_BUSY: v = st.out_busy;
            default:    v = 1'b0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        uw       = rom(pc_reg);
        hold_now = test(uw.hold, in_valid, status);
        jmp_now  = test(uw.jmp, in_valid, status);
        if (hold_now)
            pc_next = pc_reg;
        else if (jmp_now)
            pc_next = uw.target;
        else
            pc_next = pc_reg + step_t'(1);
    end

    always_comb
    begin
        ctrl.op = uw.op;
        unique case (uw.op)
            OP_LOAD: ctrl.exec = in_valid;
            OP_FIN:  ctrl.exec = !status.out_busy;
            default: ctrl.exec = 1'b1;
        endcase
    end

    assign in_ready = (uw.op == OP_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= ST_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule

// ===== sv/srbc_datapath.sv =====
module srbc_datapath import srbc_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  seq_ctrl_t            ctrl,
    input  logic                 func,
    input  logic [DATA_W-1:0]    high_in,
    input  logic [DATA_W-1:0]    low_in,
    input  logic [EXP_BITS-1:0]  key_exponent,
    input  logic [DATA_W-1:0]    key_modulus,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [DATA_W-1:0]    high_out,
    output logic [DATA_W-1:0]    low_out,
    output logic                 overflow,
    output dp_status_t           status
);

    logic [DATA_W-1:0]    n_reg;
    logic [EXP_BITS-1:0]  exp_reg;
    logic [DATA_W-1:0]    acc_reg;
    logic [DATA_W-1:0]    base_reg;
    logic [DATA_W-1:0]    q_reg;
    logic [DATA_W-1:0]    hi_reg;
    logic                 func_reg;
    logic [RED_CNT_W-1:0] red_cnt_reg;

    logic                 out_valid_reg;
    logic [DATA_W-1:0]    high_out_reg;
    logic [DATA_W-1:0]    low_out_reg;
    logic                 overflow_reg;

    logic                 do_load, do_red, do_base, do_mul, do_upd, do_fin;
    logic [DATA_W-1:0]    n_eff;
    logic [EXP_BITS-1:0]  e_eff;
    logic [PROD_W-1:0]    prod_acc;
    logic [PROD_W-1:0]    prod_base;
    logic [PROD_W-1:0]    div_a;
    logic [PROD_W-1:0]    sum;
    logic [DATA_W-1:0]    rem_a, quot_a, rem_b, quot_b;
    logic                 sum_ovf;

    assign do_load = ctrl.exec && (ctrl.op == OP_LOAD);
    assign do_red  = ctrl.exec && (ctrl.op == OP_RED);
    assign do_base = ctrl.exec && (ctrl.op == OP_BASE);
    assign do_mul  = ctrl.exec && (ctrl.op == OP_MUL);
    assign do_upd  = ctrl.exec && (ctrl.op == OP_UPD);
    assign do_fin  = ctrl.exec && (ctrl.op == OP_FIN);

    // Zero modulus acts as one, zero exponent as one.
    assign n_eff = (key_modulus == '0) ? DATA_W'(1) : key_modulus;
    assign e_eff = (key_exponent == '0) ? EXP_BITS'(1) : key_exponent;

    assign prod_acc  = PROD_W'(acc_reg) * PROD_W'(base_reg);
    assign prod_base = PROD_W'(base_reg) * PROD_W'(base_reg);
    assign div_a     = do_mul ? prod_acc : {{(PROD_W-DATA_W){1'b0}}, low_in};

    srbc_modred u_lane_a (
        .clk      (clk),
        .load     (do_load || do_mul),
        .step     (do_red),
        .dividend (div_a),
        .modulus  (do_load ? n_eff : n_reg),
        .rem      (rem_a),
        .quot     (quot_a)
    );

    srbc_modred u_lane_b (
        .clk      (clk),
        .load     (do_mul),
        .step     (do_red),
        .dividend (prod_base),
        .modulus  (n_reg),
        .rem      (rem_b),
        .quot     (quot_b)
    );

    // Decrypt result: residue plus q * n, saturated to a byte.
    assign sum     = PROD_W'(acc_reg) + PROD_W'(hi_reg) * PROD_W'(n_reg);
    assign sum_ovf = (sum[PROD_W-1:DATA_W] != '0);

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            n_reg    <= n_eff;
            exp_reg  <= e_eff;
            acc_reg  <= (n_eff == DATA_W'(1)) ? '0 : DATA_W'(1);
            hi_reg   <= high_in;
            func_reg <= func;
        end
        if (do_base)
        begin
            base_reg <= rem_a;
            q_reg    <= quot_a;
        end
        if (do_upd)
        begin
            if (exp_reg[0])
                acc_reg <= rem_a;
            base_reg <= rem_b;
            exp_reg  <= exp_reg >> 1;
        end
        if (do_fin)
        begin
            if (!func_reg)
            begin
                high_out_reg <= q_reg;
                low_out_reg  <= acc_reg;
                overflow_reg <= 1'b0;
            end
            else
            begin
                high_out_reg <= '0;
                low_out_reg  <= sum_ovf ? {DATA_W{1'b1}} : sum[DATA_W-1:0];
                overflow_reg <= sum_ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_load || do_mul)
                red_cnt_reg <= '0;
            else if (do_red)
                red_cnt_reg <= red_cnt_reg + RED_CNT_W'(1);

            if (do_fin)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.red_more = (red_cnt_reg != RED_CNT_W'(RED_STEPS - 1));
    assign status.exp_more = (exp_reg[EXP_BITS-1:1] != '0);
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign high_out  = high_out_reg;
    assign low_out   = low_out_reg;
    assign overflow  = overflow_reg;

endmodule
